FILE: hw/rtl/eps_pkg.sv
package eps_pkg;

    localparam int PEAK_W  = 16;
    localparam int GAIN_W  = 12;
    localparam int PCT_W   = 7;
    localparam int FS_W    = 16;
    localparam int ST_W    = 2;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam int QUEUE_DEPTH_DEF = 2;

    // Products peak*100 and target*full_scale both stay below 2**23.
    localparam int PROD_W = 23;
    localparam int ERR_W  = PROD_W + 1;

    localparam int PCT_FULL = 100;

    // The error is off by more than 0.001 % whenever 1000*|err| > full_scale.
    // Any |err| of EXACT_LIM or more clears every 16-bit full scale.
    localparam int EXACT_SCALE = 1000;
    localparam int EXACT_LIM   = 66;
    localparam int EXACT_IDX_W = 7;
    localparam int EXACT_W     = 17;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_COARSE = 3'd6;
    localparam logic [STEP_W-1:0] STEP_FINE   = 3'd1;

    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

    localparam logic              RST_MODE           = 1'b0;
    localparam logic [PCT_W-1:0]  RST_TARGET_PCT     = 7'd80;
    localparam logic [FS_W-1:0]   RST_FULL_SCALE     = 16'd255;
    localparam logic [GAIN_W-1:0] RST_MIN_GAIN       = 12'd0;
    localparam logic [GAIN_W-1:0] RST_MAX_TOTAL_GAIN = 12'd2200;
    localparam logic [GAIN_W-1:0] RST_START_GAIN     = 12'd0;
    localparam logic [GAIN_W-1:0] RST_START_REF_GAIN = 12'd0;

    typedef enum logic [2:0] {
        REG_MODE           = 3'd0,
        REG_TARGET_PCT     = 3'd1,
        REG_FULL_SCALE     = 3'd2,
        REG_MIN_GAIN       = 3'd3,
        REG_MAX_TOTAL_GAIN = 3'd4,
        REG_START_GAIN     = 3'd5,
        REG_START_REF_GAIN = 3'd6
    } reg_idx_t;

    typedef enum logic [ST_W-1:0] {
        ST_RUNNING = 2'd0,
        ST_DONE    = 2'd1,
        ST_FAILED  = 2'd2,
        ST_IDLE    = 2'd3
    } status_t;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic {
        MODE_BASE = 1'b0,
        MODE_REF  = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [PCT_W-1:0]  target_pct;
        logic [FS_W-1:0]   full_scale;
        logic [GAIN_W-1:0] min_gain;
        logic [GAIN_W-1:0] max_total_gain;
        logic [GAIN_W-1:0] start_gain;
        logic [GAIN_W-1:0] start_ref_gain;
    } cfg_t;

    typedef struct packed {
        cmd_t cmd;
        logic above;
        logic coarse;
        logic off_target;
        logic inexact;
    } cls_t;

endpackage

FILE: hw/rtl/eps_if.sv
interface eps_in_if import eps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [PEAK_W-1:0] peak_amp;

    modport source (output valid, output command, output peak_amp, input ready);
    modport sink (input valid, input command, input peak_amp, output ready);
endinterface

interface eps_out_if import eps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] base_gain_out;
    logic [GAIN_W-1:0] ref_gain_out;
    logic [ST_W-1:0]   status;

    modport source (output valid, output base_gain_out, output ref_gain_out, output status,
                    input ready);
    modport sink (input valid, input base_gain_out, input ref_gain_out, input status,
                  output ready);
endinterface

FILE: hw/rtl/eps_cfg.sv
module eps_cfg import eps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MODE:           cfg_next.mode           = mode_t'(pwdata[0]);
                REG_TARGET_PCT:     cfg_next.target_pct     = pwdata[PCT_W-1:0];
                REG_FULL_SCALE:     cfg_next.full_scale     = pwdata[FS_W-1:0];
                REG_MIN_GAIN:       cfg_next.min_gain       = pwdata[GAIN_W-1:0];
                REG_MAX_TOTAL_GAIN: cfg_next.max_total_gain = pwdata[GAIN_W-1:0];
                REG_START_GAIN:     cfg_next.start_gain     = pwdata[GAIN_W-1:0];
                REG_START_REF_GAIN: cfg_next.start_ref_gain = pwdata[GAIN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODE:           prdata = PDATA_W'(cfg_reg.mode);
            REG_TARGET_PCT:     prdata = PDATA_W'(cfg_reg.target_pct);
            REG_FULL_SCALE:     prdata = PDATA_W'(cfg_reg.full_scale);
            REG_MIN_GAIN:       prdata = PDATA_W'(cfg_reg.min_gain);
            REG_MAX_TOTAL_GAIN: prdata = PDATA_W'(cfg_reg.max_total_gain);
            REG_START_GAIN:     prdata = PDATA_W'(cfg_reg.start_gain);
            REG_START_REF_GAIN: prdata = PDATA_W'(cfg_reg.start_ref_gain);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= mode_t'(RST_MODE);
            cfg_reg.target_pct     <= RST_TARGET_PCT;
            cfg_reg.full_scale     <= RST_FULL_SCALE;
            cfg_reg.min_gain       <= RST_MIN_GAIN;
            cfg_reg.max_total_gain <= RST_MAX_TOTAL_GAIN;
            cfg_reg.start_gain     <= RST_START_GAIN;
            cfg_reg.start_ref_gain <= RST_START_REF_GAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/eps_front.sv
module eps_front import eps_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    eps_in_if.sink sample_ch,
    input  logic   q_full,
    output logic   push,
    output cls_t   push_data
);

    logic                     valid_reg;
    logic                     valid_next;
    cmd_t                     cmd_reg;
    logic [PROD_W-1:0]        peak_prod_reg;
    logic [PROD_W-1:0]        tgt_prod_reg;
    logic [FS_W-1:0]          fs_reg;
    logic [FS_W-1:0]          fs_eff;
    logic                     accept;
    logic signed [ERR_W-1:0]  err;
    logic [PROD_W-1:0]        aerr;
    logic [PROD_W-1:0]        fs_wide;
    logic [PROD_W-1:0]        fs5;
    logic [EXACT_W-1:0]       aerr_scaled;

    assign fs_eff          = (cfg.full_scale == '0) ? FS_W'(1) : cfg.full_scale;
    assign sample_ch.ready = !valid_reg || !q_full;
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign push            = valid_reg && !q_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= cmd_t'(sample_ch.command);
            peak_prod_reg <= PROD_W'(sample_ch.peak_amp) * PROD_W'(PCT_FULL);
            tgt_prod_reg  <= PROD_W'(cfg.target_pct) * PROD_W'(fs_eff);
            fs_reg        <= fs_eff;
        end
    end

    always_comb
    begin
        err         = $signed({1'b0, peak_prod_reg}) - $signed({1'b0, tgt_prod_reg});
        aerr        = err[ERR_W-1] ? PROD_W'(-err) : PROD_W'(err);
        fs_wide     = PROD_W'(fs_reg);
        fs5         = (fs_wide << 2) + fs_wide;
        aerr_scaled = EXACT_W'(aerr[EXACT_IDX_W-1:0]) * EXACT_W'(EXACT_SCALE);

        push_data.cmd        = cmd_reg;
        push_data.above      = !err[ERR_W-1] && (err != '0);
        push_data.coarse     = aerr > fs5;
        push_data.off_target = aerr > fs_wide;
        push_data.inexact    = (aerr >= PROD_W'(EXACT_LIM)) ||
                               (aerr_scaled > EXACT_W'(fs_reg));
    end

endmodule

FILE: hw/rtl/eps_queue.sv
module eps_queue import eps_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    output logic full,
    output logic pop_valid,
    output cls_t pop_data,
    input  logic pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("word written into a full queue");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("word read from an empty queue");
`endif

endmodule

FILE: hw/rtl/eps_back.sv
module eps_back import eps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       pop_valid,
    input  cls_t       pop_data,
    output logic       pop,
    eps_out_if.source  result_ch
);

    localparam int SW = GAIN_W + 3;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [GAIN_W-1:0] base_gain_reg;
    logic [GAIN_W-1:0] base_gain_next;
    logic [GAIN_W-1:0] ref_gain_reg;
    logic [GAIN_W-1:0] ref_gain_next;
    logic              running_reg;
    logic              running_next;
    status_t           status_reg;
    status_t           status_next;

    logic [STEP_W-1:0] step;
    logic signed [SW-1:0] b_s;
    logic signed [SW-1:0] r_s;
    logic signed [SW-1:0] mn_s;
    logic signed [SW-1:0] mx_s;
    logic signed [SW-1:0] st_s;
    logic signed [SW-1:0] adj_s;
    logic signed [SW-1:0] dec_s;
    logic signed [SW-1:0] lo_s;
    logic signed [SW-1:0] hi_s;
    logic [GAIN_W-1:0]    new_gain;
    logic [GAIN_W:0]      sum0;
    logic [GAIN_W:0]      sum1;
    logic                 fail;

    function automatic logic [GAIN_W-1:0] sat_gain(input logic signed [SW-1:0] v);
        logic [GAIN_W-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > $signed({{(SW-GAIN_W){1'b0}}, GAIN_MAX}))
        begin
            res = GAIN_MAX;
        end
        else
        begin
            res = v[GAIN_W-1:0];
        end
        return res;
    endfunction

    assign pop                     = pop_valid && (!out_valid_reg || result_ch.ready);
    assign result_ch.valid         = out_valid_reg;
    assign result_ch.base_gain_out = base_gain_reg;
    assign result_ch.ref_gain_out  = ref_gain_reg;
    assign result_ch.status        = status_reg;

    always_comb
    begin
        step  = pop_data.coarse ? STEP_COARSE : STEP_FINE;
        b_s   = $signed({{(SW-GAIN_W){1'b0}}, base_gain_reg});
        r_s   = $signed({{(SW-GAIN_W){1'b0}}, ref_gain_reg});
        mn_s  = $signed({{(SW-GAIN_W){1'b0}}, cfg.min_gain});
        mx_s  = $signed({{(SW-GAIN_W){1'b0}}, cfg.max_total_gain});
        st_s  = $signed({{(SW-STEP_W){1'b0}}, step});
        adj_s = (cfg.mode == MODE_REF) ? r_s : b_s;
        dec_s = adj_s - st_s;
        lo_s  = (dec_s > mn_s) ? dec_s : mn_s;
        if (cfg.mode == MODE_REF)
        begin
            hi_s = r_s + st_s;
        end
        else
        begin
            hi_s = (b_s + r_s + st_s > mx_s) ? mx_s - r_s : b_s + st_s;
        end
        new_gain = sat_gain(pop_data.above ? lo_s : hi_s);
        sum0     = {1'b0, new_gain} + {1'b0, ref_gain_reg};
        sum1     = {1'b0, base_gain_reg} + {1'b0, new_gain};
        if (cfg.mode == MODE_REF)
        begin
            fail = (new_gain == '0) || (sum1 > {1'b0, cfg.max_total_gain});
        end
        else
        begin
            fail = ((new_gain == cfg.min_gain) || (sum0 == {1'b0, cfg.max_total_gain}))
                   && pop_data.inexact;
        end
    end

    always_comb
    begin
        base_gain_next = base_gain_reg;
        ref_gain_next  = ref_gain_reg;
        running_next   = running_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next = 1'b1;
            if (pop_data.cmd == CMD_START)
            begin
                base_gain_next = cfg.start_gain;
                ref_gain_next  = cfg.start_ref_gain;
                running_next   = 1'b1;
                status_next    = ST_RUNNING;
            end
            else if (!running_reg)
            begin
                status_next = ST_IDLE;
            end
            else
            begin
                if (cfg.mode == MODE_REF)
                begin
                    ref_gain_next = new_gain;
                end
                else
                begin
                    base_gain_next = new_gain;
                end
                if (fail)
                begin
                    status_next  = ST_FAILED;
                    running_next = 1'b0;
                end
                else if (pop_data.off_target)
                begin
                    status_next = ST_RUNNING;
                end
                else
                begin
                    status_next  = ST_DONE;
                    running_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            base_gain_reg <= '0;
            ref_gain_reg  <= '0;
            running_reg   <= 1'b0;
            status_reg    <= ST_IDLE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            base_gain_reg <= base_gain_next;
            ref_gain_reg  <= ref_gain_next;
            running_reg   <= running_next;
            status_reg    <= status_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_data.cmd == CMD_START) |=>
            (running_reg && out_valid_reg && status_reg == ST_RUNNING))
        else $error("start word did not begin a run");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_data.cmd == CMD_SAMPLE && !running_reg) |=>
            (status_reg == ST_IDLE && $stable(base_gain_reg) && $stable(ref_gain_reg)))
        else $error("sample while idle changed the gains");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ch.ready) |=>
            ($stable(base_gain_reg) && $stable(ref_gain_reg) && $stable(running_reg)))
        else $error("gain state moved while a result waited");

    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_DONE || status_reg == ST_FAILED)) |-> !running_reg)
        else $error("run still active after done or fail");
`endif

endmodule

FILE: hw/rtl/echo_peak_auto_gain_stepper.sv
// Echo peak auto gain stepper.
// The sample channel takes one word per cycle while ready is high:
// command 0 starts a run and loads the start gains, command 1 carries a
// peak amplitude sample. Every accepted word yields exactly one result
// word on the result channel with the base gain, the reference gain and a
// status code. The APB port holds the seven setup registers at byte
// addresses 4*i; they must be written only while no word is in flight,
// as the block itself does not enforce this. The front stage registers
// the error products, a short queue holds classified words, and the back
// stage registers the new gains. One word per cycle is sustained while the
// receiver takes results; the back stage gain update loop sets that rate.
// When the receiver stalls, the result register holds its word, the queue
// fills, and the sample channel drops ready once front stage and queue are
// full. Reset clears both gains, leaves the block idle, empties the queue
// and restores the register defaults.
module echo_peak_auto_gain_stepper import eps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    eps_in_if.sink             sample_ch,
    eps_out_if.source          result_ch
);

    cfg_t cfg;
    logic push;
    cls_t push_data;
    logic q_full;
    logic pop_valid;
    cls_t pop_data;
    logic pop;

    eps_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    eps_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sample_ch (sample_ch),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    eps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop)
    );

    eps_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule
